FILE: sv/b13_pkg.sv
`timescale 1ns / 1ps

package b13_pkg;

    // Fixed widths of the word fields.
    localparam int DIGITS_W = 40;
    localparam int VALUE_W  = 38;

    // Operation codes.
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_SUB     = 2'd1;
    localparam logic [1:0] OP_BIN2DIG = 2'd2;
    localparam logic [1:0] OP_DIG2BIN = 2'd3;

    typedef struct packed {
        logic [1:0]          operation;
        logic [DIGITS_W-1:0] operand_a;
        logic [DIGITS_W-1:0] operand_b;
        logic [VALUE_W-1:0]  binary_value;
    } b13_req_t;

    typedef struct packed {
        logic [DIGITS_W-1:0] result_digits;
        logic [VALUE_W-1:0]  result_value;
        logic                overflow;
    } b13_rsp_t;

    // Control that travels with a word from cell to cell. The flag is the
    // column carry or borrow for add and subtract, and the sticky overflow
    // for the two conversions.
    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic       flag;
    } b13_ctl_t;

endpackage

FILE: sv/b13_chan_if.sv
`timescale 1ns / 1ps

interface b13_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

FILE: sv/b13_cell.sv
`timescale 1ns / 1ps

module b13_cell #(
    parameter int NUM_DIGITS = 10,
    parameter int RADIX      = 13,
    parameter int CELL_IDX   = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  b13_pkg::b13_ctl_t           ctl_in,
    input  logic [4*NUM_DIGITS-1:0]     a_in,
    input  logic [4*NUM_DIGITS-1:0]     b_in,
    input  logic [b13_pkg::VALUE_W-1:0] work_in,
    output b13_pkg::b13_ctl_t           ctl_out,
    output logic [4*NUM_DIGITS-1:0]     a_out,
    output logic [4*NUM_DIGITS-1:0]     b_out,
    output logic [b13_pkg::VALUE_W-1:0] work_out
);
    import b13_pkg::*;

    localparam int         DIG_W  = 4 * NUM_DIGITS;
    localparam bit         ACTIVE = (CELL_IDX < NUM_DIGITS);
    // Column handled by add and subtract, and the digit taken by the Horner step.
    localparam int         COL_LO = ACTIVE ? 4 * CELL_IDX : 0;
    localparam int         SRC_LO = ACTIVE ? 4 * (NUM_DIGITS - 1 - CELL_IDX) : 0;
    localparam int         PROD_W = VALUE_W + 5;
    localparam logic [4:0] RADIX5 = 5'(RADIX);
    localparam logic [5:0] RADIX6 = 6'(RADIX);

    b13_ctl_t           ctl_reg, ctl_next;
    logic [DIG_W-1:0]   a_reg, a_next;
    logic [DIG_W-1:0]   b_reg, b_next;
    logic [VALUE_W-1:0] work_reg, work_next;

    logic [3:0]         mod_tbl [32];
    logic [3:0]         a_dig, b_dig, src_dig;
    logic [4:0]         col_sum;
    logic [5:0]         col_diff, col_fix;
    logic [3:0]         add_dig, sub_dig;
    logic               add_cy, sub_bw;
    logic [DIG_W-1:0]   dbl_dig;
    logic               dbl_cy;
    logic [PROD_W-1:0]  horner;

    // Remainder table for column sums up to 31.
    for (genvar s = 0; s < 32; s++) begin : g_mod
        localparam logic [3:0] MOD_VAL = 4'(s % RADIX);
        assign mod_tbl[s] = MOD_VAL;
    end

    // One column of add or subtract.
    always_comb begin
        a_dig    = a_in[COL_LO +: 4];
        b_dig    = b_in[COL_LO +: 4];
        col_sum  = 5'(a_dig) + 5'(b_dig) + 5'(ctl_in.flag);
        add_dig  = mod_tbl[col_sum];
        add_cy   = (col_sum >= RADIX5);
        col_diff = 6'(a_dig) - 6'(b_dig) - 6'(ctl_in.flag);
        col_fix  = col_diff + RADIX6;
        sub_bw   = col_diff[5];
        sub_dig  = sub_bw ? col_fix[3:0] : col_diff[3:0];
    end

    // Doubling of all digits with the next binary bit shifted in at the
    // bottom. Carries use generate and propagate terms as in an adder.
    always_comb begin
        logic [4:0] twice;
        logic [4:0] t;
        logic       cy;
        cy      = work_in[VALUE_W-1];
        dbl_dig = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            twice = {a_in[4*i +: 4], 1'b0};
            t     = twice + 5'(cy);
            cy    = (twice >= RADIX5) | ((twice == (RADIX5 - 5'd1)) & cy);
            dbl_dig[4*i +: 4] = cy ? 4'(t - RADIX5) : t[3:0];
        end
        dbl_cy = cy;
    end

    // Horner step, most significant digit first.
    always_comb begin
        src_dig = a_in[SRC_LO +: 4];
        horner  = PROD_W'(work_in) * PROD_W'(RADIX) + PROD_W'(src_dig);
    end

    always_comb begin
        ctl_next  = ctl_in;
        a_next    = a_in;
        b_next    = b_in;
        work_next = work_in;
        unique case (ctl_in.op)
            OP_ADD: begin
                if (ACTIVE) begin
                    a_next[COL_LO +: 4] = add_dig;
                    ctl_next.flag       = add_cy;
                end
            end
            OP_SUB: begin
                if (ACTIVE) begin
                    a_next[COL_LO +: 4] = sub_dig;
                    ctl_next.flag       = sub_bw;
                end
            end
            OP_BIN2DIG: begin
                a_next        = dbl_dig;
                work_next     = work_in << 1;
                ctl_next.flag = ctl_in.flag | dbl_cy;
            end
            OP_DIG2BIN: begin
                if (ACTIVE) begin
                    work_next     = horner[VALUE_W-1:0];
                    ctl_next.flag = ctl_in.flag | (|horner[PROD_W-1:VALUE_W]);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            work_reg <= work_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign work_out = work_reg;

endmodule

FILE: sv/b13_out_buf.sv
`timescale 1ns / 1ps

module b13_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b13_pkg::b13_rsp_t push_word,
    output logic              full,
    b13_chan_if.source        rsp
);
    import b13_pkg::*;

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    b13_rsp_t   entry_reg [2];
    logic       pop;

    assign pop         = rsp.valid && rsp.ready;
    assign rsp.valid   = (count_reg != 2'd0);
    assign rsp.payload = entry_reg[rd_ptr_reg];
    assign full        = (count_reg == 2'd2);

    always_comb begin
        count_next  = count_reg + 2'(push) - 2'(pop);
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: sv/base13_digit_arithmetic_unit.sv
// Channel  Direction  Word                                                   Handshake
// req      in         operation, operand_a, operand_b, binary_value          valid/ready
// rsp      out        result_digits, result_value, overflow                  valid/ready
//
// One word is accepted per cycle while the output buffer has room. Each word
// passes through every cell of a 38-cell chain at the default settings (one cell
// per bit of binary_value) and is then written into the output buffer, so the
// length of the chain sets the latency.
// Reset clears the valid bits of the chain and the output buffer count.
// The chain only halts while two results wait in the output buffer; with one
// waiting, req stays ready.
`timescale 1ns / 1ps

module base13_digit_arithmetic_unit #(
    parameter int NUM_DIGITS = 10,
    parameter int RADIX      = 13
) (
    input  logic       clk,
    input  logic       rst_n,
    b13_chan_if.sink   req,
    b13_chan_if.source rsp
);
    import b13_pkg::*;

    // Each digit is a four-bit nibble inside the chain, whatever the port widths.
    localparam int DIG_W     = 4 * NUM_DIGITS;
    // The chain must be long enough for one cell per binary bit in the
    // conversion to digits, and one cell per digit for the other operations.
    localparam int NUM_CELLS = (NUM_DIGITS > VALUE_W) ? NUM_DIGITS : VALUE_W;
    localparam int MAX_FLIGHT = NUM_CELLS + 2;
    localparam int FLIGHT_W   = $clog2(MAX_FLIGHT + 1);

    b13_req_t           req_word;
    b13_ctl_t           ctl_chain  [NUM_CELLS+1];
    logic [DIG_W-1:0]   a_chain    [NUM_CELLS+1];
    logic [DIG_W-1:0]   b_chain    [NUM_DIGITS];
    logic [VALUE_W-1:0] work_chain [NUM_CELLS+1];
    b13_ctl_t           last_ctl;
    b13_rsp_t           result;
    logic               en;
    logic               ob_full;
    logic               push;

    // The whole chain moves together. It is held only when the output buffer
    // is full, which is a registered condition, so no ready path runs back
    // through the chain.
    assign en        = !ob_full;
    assign req.ready = en;
    assign req_word  = req.payload;

    // Entry to the chain. For the conversion to digits the digit word starts
    // at zero and the binary value is shifted out from its top bit; for the
    // conversion to binary the accumulator starts at zero. The carry, borrow
    // and overflow flag always starts clear.
    assign ctl_chain[0]  = '{valid: req.valid, op: req_word.operation, flag: 1'b0};
    assign a_chain[0]    = (req_word.operation == OP_BIN2DIG) ? '0
                                                              : DIG_W'(req_word.operand_a);
    assign b_chain[0]    = DIG_W'(req_word.operand_b);
    assign work_chain[0] = (req_word.operation == OP_BIN2DIG) ? req_word.binary_value : '0;

    // Cell k handles column k of add and subtract, digit NUM_DIGITS-1-k of the
    // conversion to binary, and binary bit k (from the top) of the conversion
    // to digits. Cells beyond the last digit pass the digit operations along.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        localparam int B_IDX = (k < NUM_DIGITS) ? k : NUM_DIGITS - 1;
        if (k < NUM_DIGITS - 1) begin : g_col
            b13_cell #(
                .NUM_DIGITS (NUM_DIGITS),
                .RADIX      (RADIX),
                .CELL_IDX   (k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .ctl_in   (ctl_chain[k]),
                .a_in     (a_chain[k]),
                .b_in     (b_chain[B_IDX]),
                .work_in  (work_chain[k]),
                .ctl_out  (ctl_chain[k+1]),
                .a_out    (a_chain[k+1]),
                .b_out    (b_chain[k+1]),
                .work_out (work_chain[k+1])
            );
        end else begin : g_tail
            // The second operand is no longer needed after the top column.
            b13_cell #(
                .NUM_DIGITS (NUM_DIGITS),
                .RADIX      (RADIX),
                .CELL_IDX   (k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .ctl_in   (ctl_chain[k]),
                .a_in     (a_chain[k]),
                .b_in     (b_chain[B_IDX]),
                .work_in  (work_chain[k]),
                .ctl_out  (ctl_chain[k+1]),
                .a_out    (a_chain[k+1]),
                .b_out    (),
                .work_out (work_chain[k+1])
            );
        end
    end

    // Shape the result at the end of the chain. The conversion to binary
    // gives no digits, and the other operations give no binary value.
    assign last_ctl = ctl_chain[NUM_CELLS];

    always_comb begin
        result.result_digits = (last_ctl.op == OP_DIG2BIN) ? '0
                                                           : DIGITS_W'(a_chain[NUM_CELLS]);
        result.result_value  = (last_ctl.op == OP_DIG2BIN) ? work_chain[NUM_CELLS] : '0;
        result.overflow      = last_ctl.flag;
    end

    assign push = last_ctl.valid && en;

    b13_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (result),
        .full      (ob_full),
        .rsp       (rsp)
    );

    // Count of words accepted and not yet delivered, kept for the checks below.
    logic [FLIGHT_W-1:0] flight_reg, flight_next;

    assign flight_next = flight_reg + FLIGHT_W'(req.valid && req.ready)
                                    - FLIGHT_W'(rsp.valid && rsp.ready);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            flight_reg <= '0;
        end else begin
            flight_reg <= flight_next;
        end
    end

    // A result may only leave when some request is still outstanding.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready) |-> (flight_reg != '0))
        else $error("result delivered with no request outstanding");

    // The chain and buffer together never hold more than they have room for.
    a_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= FLIGHT_W'(MAX_FLIGHT))
        else $error("more words in flight than the chain and buffer can hold");

    // Nothing is offered when nothing is outstanding.
    a_empty_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (flight_reg == '0) |-> !rsp.valid)
        else $error("result offered with the unit empty");

    // Requests are only refused while a result is waiting to be taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> rsp.valid)
        else $error("request refused with no result waiting");

    // Only one of the two result fields can carry a value.
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.payload.result_digits == '0) || (rsp.payload.result_value == '0)))
        else $error("both digit and binary results are non-zero");

endmodule

FILE: test/base13_digit_arithmetic_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the base-13 arithmetic unit. Request words go in through
// the req channel and result words come back through the rsp channel, one for
// each request, in order. Each result is compared field by field with the
// oldest outstanding expectation.
module base13_digit_arithmetic_unit_tb;

    import b13_pkg::*;

    // Geometry of the numbers, as the block is instantiated below.
    localparam int DIGIT_COUNT = 10;
    localparam int BASE        = 13;

    // Thirteen to the tenth: the first value that no longer fits ten digits.
    localparam logic [63:0] BASE_POW    = 64'd137858491849;
    localparam logic [39:0] ALL_TWELVE  = 40'hCC_CCCC_CCCC;
    localparam logic [39:0] ALL_FIFTEEN = 40'hFF_FFFF_FFFF;

    localparam int RANDOM_WORDS    = 1800;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int MAX_REPORTS     = 10;

    // One row of the directed table. Where typed is set the expected result is
    // written out by hand; otherwise the arithmetic predictor supplies it.
    typedef struct {
        b13_req_t word;
        bit       typed;
        b13_rsp_t want;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n;

    b13_chan_if #(.payload_t(b13_req_t)) req_ch ();
    b13_chan_if #(.payload_t(b13_rsp_t)) rsp_ch ();

    base13_digit_arithmetic_unit #(
        .NUM_DIGITS (DIGIT_COUNT),
        .RADIX      (BASE)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    table_row_t directed_table[$];
    b13_rsp_t   outstanding_results[$];
    b13_rsp_t   oldest;
    int         fault_count  = 0;
    int         quiet_cycles = 0;

    // Set by the request side. While calm is high neither side idles. Each
    // step of the hold-off count asks the response side to stall for a long
    // stretch; the response side keeps its own count of the stalls it has done.
    bit calm           = 1'b0;
    int hold_off_asked = 0;
    int hold_off_done  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Works out the result word of one request. Add and subtract ripple a
    // carry or borrow through the columns from the least significant digit
    // upward, taking each digit at its face value even when it is thirteen
    // or more. The conversions run over a 64-bit accumulator so that bits
    // lost to the field widths can be seen.
    function automatic b13_rsp_t predict_result(input b13_req_t word);
        b13_rsp_t    res;
        logic [63:0] acc;
        int          col;
        int          da;
        int          db;
        int          ripple;
        res    = '0;
        ripple = 0;
        case (word.operation)
            OP_ADD:
            begin
                for (int i = 0; i < DIGIT_COUNT; i++)
                begin
                    da  = word.operand_a[4*i +: 4];
                    db  = word.operand_b[4*i +: 4];
                    col = da + db + ripple;
                    if (col >= BASE)
                    begin
                        col    = col % BASE;
                        ripple = 1;
                    end
                    else
                    begin
                        ripple = 0;
                    end
                    res.result_digits[4*i +: 4] = col[3:0];
                end
                res.overflow = (ripple != 0);
            end
            OP_SUB:
            begin
                for (int i = 0; i < DIGIT_COUNT; i++)
                begin
                    da  = word.operand_a[4*i +: 4];
                    db  = word.operand_b[4*i +: 4];
                    col = da - ripple - db;
                    if (col < 0)
                    begin
                        // The digit keeps the low four bits, even when the
                        // column is still negative after adding the base.
                        col    = col + BASE;
                        ripple = 1;
                    end
                    else
                    begin
                        ripple = 0;
                    end
                    res.result_digits[4*i +: 4] = col[3:0];
                end
                res.overflow = (ripple != 0);
            end
            OP_BIN2DIG:
            begin
                acc = 64'(word.binary_value);
                for (int i = 0; i < DIGIT_COUNT; i++)
                begin
                    res.result_digits[4*i +: 4] = 4'(acc % BASE);
                    acc = acc / BASE;
                end
                res.overflow = (acc != 0);
            end
            default:
            begin
                acc = '0;
                for (int i = DIGIT_COUNT - 1; i >= 0; i--)
                begin
                    acc = acc * BASE + 64'(word.operand_a[4*i +: 4]);
                end
                res.result_value = acc[VALUE_W-1:0];
                res.overflow     = (acc[63:VALUE_W] != 0);
            end
        endcase
        return res;
    endfunction

    task automatic add_row(
        input logic [1:0]          op,
        input logic [DIGITS_W-1:0] a,
        input logic [DIGITS_W-1:0] b,
        input logic [VALUE_W-1:0]  bin,
        input bit                  typed,
        input logic [DIGITS_W-1:0] want_digits,
        input logic [VALUE_W-1:0]  want_value,
        input logic                want_overflow
    );
        table_row_t row;
        row.word.operation     = op;
        row.word.operand_a     = a;
        row.word.operand_b     = b;
        row.word.binary_value  = bin;
        row.typed              = typed;
        row.want.result_digits = want_digits;
        row.want.result_value  = want_value;
        row.want.overflow      = want_overflow;
        directed_table.push_back(row);
    endtask

    // Mostly digits below the base, now and then the largest legal number,
    // and now and then arbitrary nibbles so that every bit toggles.
    function automatic logic [DIGITS_W-1:0] random_digits();
        logic [DIGITS_W-1:0] w;
        int                  pick;
        w    = DIGITS_W'({$urandom, $urandom});
        pick = $urandom_range(9);
        if (pick == 7)
        begin
            w = ALL_TWELVE;
        end
        else if (pick < 7)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                w[4*i +: 4] = 4'($urandom_range(BASE - 1));
            end
        end
        return w;
    endfunction

    // Binary values spread over the whole field, within range, close to the
    // ten-digit boundary on either side, and small.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       v = v;
            1:       v = v % BASE_POW;
            2:       v = BASE_POW - 64'd8 + 64'($urandom_range(15));
            default: v = 64'($urandom_range(255));
        endcase
        return v[VALUE_W-1:0];
    endfunction

    // Offers one request word and holds it until the block takes it. Gaps of
    // random length go in front of the word unless the bench is calm. The
    // expectation is queued at the edge that accepts the word.
    task automatic send_word(input b13_req_t word, input b13_rsp_t want);
        while (!calm && $urandom_range(99) < 14)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= word;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        outstanding_results.push_back(want);
    endtask

    // Lowers valid and waits for every outstanding result to come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (outstanding_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic note_fault(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        if (fault_count < MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
        end
        fault_count++;
    endtask

    // Request side: reset, the directed table, then the random words.
    initial
    begin
        b13_req_t word;
        b13_rsp_t want;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        rst_n          <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Adds: zero, carry out of the top digit, the largest number plus
        // nothing, a carry into the second digit, a column sum exactly equal
        // to the base, and digits of fifteen in every column.
        add_row(OP_ADD, '0, '0, '0, 1'b1, '0, '0, 1'b0);
        add_row(OP_ADD, ALL_TWELVE, 40'h1, '0, 1'b1, '0, '0, 1'b1);
        add_row(OP_ADD, ALL_TWELVE, '0, '1, 1'b1, ALL_TWELVE, '0, 1'b0);
        add_row(OP_ADD, 40'h1, 40'hC, '0, 1'b1, 40'h10, '0, 1'b0);
        add_row(OP_ADD, 40'h7, 40'h6, '0, 1'b1, 40'h10, '0, 1'b0);
        add_row(OP_ADD, ALL_FIFTEEN, ALL_FIFTEEN, '1, 1'b0, '0, '0, 1'b0);
        // Subtracts: borrow out of the top digit, equal operands, a borrow
        // out of the lowest digit, and oversized digits on either side.
        add_row(OP_SUB, '0, 40'h1, '0, 1'b1, ALL_TWELVE, '0, 1'b1);
        add_row(OP_SUB, ALL_TWELVE, ALL_TWELVE, '1, 1'b1, '0, '0, 1'b0);
        add_row(OP_SUB, 40'h10, 40'h1, '0, 1'b1, 40'hC, '0, 1'b0);
        add_row(OP_SUB, 40'h5, 40'h5, '0, 1'b1, '0, '0, 1'b0);
        add_row(OP_SUB, '0, ALL_FIFTEEN, '0, 1'b0, '0, '0, 1'b0);
        add_row(OP_SUB, ALL_FIFTEEN, '0, '0, 1'b0, '0, '0, 1'b0);
        // Binary to digits: zero, the largest value that fits, the first
        // one that does not, the top of the field, and the base itself.
        add_row(OP_BIN2DIG, '1, '1, '0, 1'b1, '0, '0, 1'b0);
        add_row(OP_BIN2DIG, '0, '0, VALUE_W'(BASE_POW - 1), 1'b1, ALL_TWELVE, '0, 1'b0);
        add_row(OP_BIN2DIG, '0, '0, VALUE_W'(BASE_POW), 1'b1, '0, '0, 1'b1);
        add_row(OP_BIN2DIG, '0, '0, '1, 1'b0, '0, '0, 1'b0);
        add_row(OP_BIN2DIG, '0, '0, VALUE_W'(BASE), 1'b1, 40'h10, '0, 1'b0);
        // Digits to binary: zero, the largest legal number, nibbles of
        // fifteen counted at face value, and one in the second digit.
        add_row(OP_DIG2BIN, '0, '1, '1, 1'b1, '0, '0, 1'b0);
        add_row(OP_DIG2BIN, ALL_TWELVE, '0, '0, 1'b1, '0, VALUE_W'(BASE_POW - 1), 1'b0);
        add_row(OP_DIG2BIN, ALL_FIFTEEN, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(OP_DIG2BIN, 40'h10, '0, '0, 1'b1, '0, VALUE_W'(BASE), 1'b0);

        foreach (directed_table[i])
        begin
            want = directed_table[i].typed ? directed_table[i].want
                                           : predict_result(directed_table[i].word);
            send_word(directed_table[i].word, want);
        end

        // Let the pipeline empty completely before the random part.
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // A long stretch in the middle runs with neither side idling.
            calm = (n >= 900 && n < 1200);
            // Here the response side stalls for a long time while words keep
            // coming, so the chain and the output buffer fill and req stalls.
            if (n == 400)
            begin
                hold_off_asked = hold_off_asked + 1;
            end
            if (n == 1400)
            begin
                drain_results();
            end
            word.operation    = 2'($urandom_range(3));
            word.operand_a    = random_digits();
            word.operand_b    = random_digits();
            word.binary_value = random_value();
            send_word(word, predict_result(word));
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && outstanding_results.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Response side: ready drops at random, except in the calm stretch and
    // during the long hold-off, which is counted out here cycle by cycle.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_asked != hold_off_done)
            begin
                rsp_ch.ready <= 1'b0;
                for (int n = 1; n < HOLD_OFF_CYCLES; n++)
                begin
                    @(posedge clk);
                end
                hold_off_done = hold_off_asked;
            end
            else
            begin
                rsp_ch.ready <= calm || ($urandom_range(99) >= 14);
            end
        end
    end

    // Checks every result word taken at an edge, and ends the run if neither
    // channel moves a word for too long.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (outstanding_results.size() == 0)
                begin
                    note_fault("result with nothing outstanding, digits", '0,
                               64'(rsp_ch.payload.result_digits));
                end
                else
                begin
                    oldest = outstanding_results.pop_front();
                    if (rsp_ch.payload.result_digits !== oldest.result_digits)
                    begin
                        note_fault("result_digits", 64'(oldest.result_digits),
                                   64'(rsp_ch.payload.result_digits));
                    end
                    if (rsp_ch.payload.result_value !== oldest.result_value)
                    begin
                        note_fault("result_value", 64'(oldest.result_value),
                                   64'(rsp_ch.payload.result_value));
                    end
                    if (rsp_ch.payload.overflow !== oldest.overflow)
                    begin
                        note_fault("overflow", 64'(oldest.overflow),
                                   64'(rsp_ch.payload.overflow));
                    end
                end
            end
            if ((rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
                (req_ch.valid === 1'b1 && req_ch.ready === 1'b1))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule
